>>> hw/rtl/spcalu_pkg.sv
// spcalu_pkg: operation codes, flag mask bits and item types of the byte/word ALU
// no dependencies; used by spcalu_core and spc700_alu_flags
`timescale 1ns / 1ps

package spcalu_pkg;

  // field widths
  localparam int unsigned ModeW = 5;
  localparam int unsigned WordW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned MaskW = 5;

  // operation codes
  localparam logic [ModeW-1:0] OP_ADC  = 5'd0;
  localparam logic [ModeW-1:0] OP_ADDW = 5'd1;
  localparam logic [ModeW-1:0] OP_AND  = 5'd2;
  localparam logic [ModeW-1:0] OP_CMP  = 5'd3;
  localparam logic [ModeW-1:0] OP_CMPW = 5'd4;
  localparam logic [ModeW-1:0] OP_EOR  = 5'd5;
  localparam logic [ModeW-1:0] OP_OR   = 5'd6;
  localparam logic [ModeW-1:0] OP_SBC  = 5'd7;
  localparam logic [ModeW-1:0] OP_SUBW = 5'd8;
  localparam logic [ModeW-1:0] OP_INC  = 5'd9;
  localparam logic [ModeW-1:0] OP_INCW = 5'd10;
  localparam logic [ModeW-1:0] OP_DEC  = 5'd11;
  localparam logic [ModeW-1:0] OP_DECW = 5'd12;
  localparam logic [ModeW-1:0] OP_ASL  = 5'd13;
  localparam logic [ModeW-1:0] OP_LSR  = 5'd14;
  localparam logic [ModeW-1:0] OP_ROL  = 5'd15;
  localparam logic [ModeW-1:0] OP_ROR  = 5'd16;

  // flag write mask bits
  localparam int unsigned MB_C = 0;
  localparam int unsigned MB_Z = 1;
  localparam int unsigned MB_H = 2;
  localparam int unsigned MB_V = 3;
  localparam int unsigned MB_N = 4;

  localparam logic [MaskW-1:0] MASK_ALL = 5'b11111;
  localparam logic [MaskW-1:0] MASK_NZ  = 5'b10010;
  localparam logic [MaskW-1:0] MASK_NZC = 5'b10011;
  localparam logic [MaskW-1:0] MASK_NONE = 5'b00000;

  // one input item
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [WordW-1:0] operand_a;
    logic [WordW-1:0] operand_b;
    logic             carry_in;
  } alu_op_t;

  // one result item
  typedef struct packed {
    logic [WordW-1:0] result;
    logic             flag_n;
    logic             flag_v;
    logic             flag_h;
    logic             flag_z;
    logic             flag_c;
    logic [MaskW-1:0] flag_write_mask;
  } alu_res_t;

endpackage

>>> hw/rtl/spcalu_core.sv
// spcalu_core: combinational ALU datapath, one operation to value, flags and mask
// depends on spcalu_pkg
`timescale 1ns / 1ps

module spcalu_core (
  input  spcalu_pkg::alu_op_t  op,
  output spcalu_pkg::alu_res_t res
);

  // byte adder operands
  logic [7:0]  a8;
  logic [7:0]  b8;
  logic [7:0]  y8;
  logic [8:0]  sum8;
  logic [7:0]  r8;
  // word adder operands
  logic [15:0] y16;
  logic [16:0] sum16;
  logic        cin16;
  // compare differences
  logic [7:0]  d8;
  logic [15:0] d16;
  // increment and decrement
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [15:0] inc16;
  logic [15:0] dec16;

  assign a8 = op.operand_a[7:0];
  assign b8 = op.operand_b[7:0];

  // byte add or subtract with carry, subtract uses inverted operand
  assign y8   = (op.mode == spcalu_pkg::OP_SBC) ? ~b8 : b8;
  assign sum8 = {1'b0, a8} + {1'b0, y8} + {8'd0, op.carry_in};
  assign r8   = sum8[7:0];

  // word add or subtract, carry forced by the operation
  assign y16   = (op.mode == spcalu_pkg::OP_SUBW) ? ~op.operand_b : op.operand_b;
  assign cin16 = (op.mode == spcalu_pkg::OP_SUBW);
  assign sum16 = {1'b0, op.operand_a} + {1'b0, y16} + {16'd0, cin16};

  // compare, increment, decrement
  assign d8    = a8 - b8;
  assign d16   = op.operand_a - op.operand_b;
  assign inc8  = a8 + 8'd1;
  assign dec8  = a8 - 8'd1;
  assign inc16 = op.operand_a + 16'd1;
  assign dec16 = op.operand_a - 16'd1;

  // operation select and flag masking
  always_comb begin
    logic [15:0] val;
    logic        fn;
    logic        fv;
    logic        fh;
    logic        fz;
    logic        fc;
    logic [4:0]  msk;
    val = '0;
    fn  = 1'b0;
    fv  = 1'b0;
    fh  = 1'b0;
    fz  = 1'b0;
    fc  = 1'b0;
    msk = spcalu_pkg::MASK_NONE;
    unique case (op.mode)
      spcalu_pkg::OP_ADC, spcalu_pkg::OP_SBC: begin
        val = {8'd0, r8};
        fn  = r8[7];
        fv  = ~(a8[7] ^ y8[7]) & (y8[7] ^ r8[7]);
        fh  = a8[4] ^ y8[4] ^ r8[4];
        fz  = (r8 == 8'd0);
        fc  = sum8[8];
        msk = spcalu_pkg::MASK_ALL;
      end
      spcalu_pkg::OP_ADDW, spcalu_pkg::OP_SUBW: begin
        val = sum16[15:0];
        fn  = sum16[15];
        fv  = ~(op.operand_a[15] ^ y16[15]) & (y16[15] ^ sum16[15]);
        fh  = op.operand_a[12] ^ y16[12] ^ sum16[12];
        fz  = (sum16[15:0] == 16'd0);
        fc  = sum16[16];
        msk = spcalu_pkg::MASK_ALL;
      end
      spcalu_pkg::OP_AND: begin
        val = {8'd0, a8 & b8};
        msk = spcalu_pkg::MASK_NZ;
      end
      spcalu_pkg::OP_EOR: begin
        val = {8'd0, a8 ^ b8};
        msk = spcalu_pkg::MASK_NZ;
      end
      spcalu_pkg::OP_OR: begin
        val = {8'd0, a8 | b8};
        msk = spcalu_pkg::MASK_NZ;
      end
      spcalu_pkg::OP_CMP: begin
        val = {8'd0, a8};
        fn  = d8[7];
        fz  = (d8 == 8'd0);
        fc  = (a8 >= b8);
        msk = spcalu_pkg::MASK_NZC;
      end
      spcalu_pkg::OP_CMPW: begin
        val = op.operand_a;
        fn  = d16[15];
        fz  = (d16 == 16'd0);
        fc  = (op.operand_a >= op.operand_b);
        msk = spcalu_pkg::MASK_NZC;
      end
      spcalu_pkg::OP_INC: begin
        val = {8'd0, inc8};
        msk = spcalu_pkg::MASK_NZ;
      end
      spcalu_pkg::OP_DEC: begin
        val = {8'd0, dec8};
        msk = spcalu_pkg::MASK_NZ;
      end
      spcalu_pkg::OP_INCW: begin
        val = inc16;
        msk = spcalu_pkg::MASK_NZ;
      end
      spcalu_pkg::OP_DECW: begin
        val = dec16;
        msk = spcalu_pkg::MASK_NZ;
      end
      spcalu_pkg::OP_ASL: begin
        val = {8'd0, a8[6:0], 1'b0};
        fc  = a8[7];
        msk = spcalu_pkg::MASK_NZC;
      end
      spcalu_pkg::OP_LSR: begin
        val = {8'd0, 1'b0, a8[7:1]};
        fc  = a8[0];
        msk = spcalu_pkg::MASK_NZC;
      end
      spcalu_pkg::OP_ROL: begin
        val = {8'd0, a8[6:0], op.carry_in};
        fc  = a8[7];
        msk = spcalu_pkg::MASK_NZC;
      end
      spcalu_pkg::OP_ROR: begin
        val = {8'd0, op.carry_in, a8[7:1]};
        fc  = a8[0];
        msk = spcalu_pkg::MASK_NZC;
      end
      default: begin
        val = '0;
        msk = spcalu_pkg::MASK_NONE;
      end
    endcase

    // logic, shift and inc/dec flags come straight from the value
    if (msk == spcalu_pkg::MASK_NZ || msk == spcalu_pkg::MASK_NZC) begin
      if (op.mode != spcalu_pkg::OP_CMP && op.mode != spcalu_pkg::OP_CMPW) begin
        if (op.mode == spcalu_pkg::OP_INCW || op.mode == spcalu_pkg::OP_DECW) begin
          fn = val[15];
        end else begin
          fn = val[7];
        end
        fz = (val == 16'd0);
      end
    end

    res.result          = val;
    res.flag_n          = fn & msk[spcalu_pkg::MB_N];
    res.flag_v          = fv & msk[spcalu_pkg::MB_V];
    res.flag_h          = fh & msk[spcalu_pkg::MB_H];
    res.flag_z          = fz & msk[spcalu_pkg::MB_Z];
    res.flag_c          = fc & msk[spcalu_pkg::MB_C];
    res.flag_write_mask = msk;
  end

endmodule

>>> hw/rtl/spc700_alu_flags.sv
// spc700_alu_flags: top level, input register, ALU datapath and result register
// depends on spcalu_pkg and spcalu_core
`timescale 1ns / 1ps

// Byte/word ALU with status flags.
// Input channel: in_valid, in_stall and the item fields in_mode, in_operand_a,
// in_operand_b, in_carry_in. An item is taken at a clock edge with in_valid
// high and in_stall low.
// Result channel: out_valid, out_stall and out_result plus the N V H Z C flags
// and out_flag_write_mask. A flag whose mask bit is clear reads as zero.
// The item is captured in the input register, passes the ALU logic and then
// lands in the result register.
// Throughput is one item per cycle; the two-register pipeline advances every
// cycle that the result register is empty or being taken.
// When out_stall holds a result, the input register still fills, so one more
// item is taken before in_stall rises; no item is lost or repeated.
// Reset (rst_n low at a clock edge) empties both registers; no result is
// pending afterwards and in_stall is low.

module spc700_alu_flags (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_mode,
  input  logic [15:0] in_operand_a,
  input  logic [15:0] in_operand_b,
  input  logic        in_carry_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_result,
  output logic        out_flag_n,
  output logic        out_flag_v,
  output logic        out_flag_h,
  output logic        out_flag_z,
  output logic        out_flag_c,
  output logic [4:0]  out_flag_write_mask
);

  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  spcalu_pkg::alu_op_t  s1_op_r;
  logic                 s2_valid_r;
  logic                 s2_valid_nxt;
  spcalu_pkg::alu_res_t s2_res_r;
  spcalu_pkg::alu_res_t alu_res;
  logic                 s2_load;
  logic                 s1_load;

  // pipeline advance
  assign s2_load  = !s2_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_stall = !s1_load;

  assign s1_valid_nxt = s1_load ? in_valid : s1_valid_r;
  assign s2_valid_nxt = s2_load ? s1_valid_r : s2_valid_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_op_r.mode      <= in_mode;
      s1_op_r.operand_a <= in_operand_a;
      s1_op_r.operand_b <= in_operand_b;
      s1_op_r.carry_in  <= in_carry_in;
    end
  end

  // alu datapath
  spcalu_core u_core (
    .op  (s1_op_r),
    .res (alu_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_res_r <= alu_res;
    end
  end

  assign out_valid           = s2_valid_r;
  assign out_result          = s2_res_r.result;
  assign out_flag_n          = s2_res_r.flag_n;
  assign out_flag_v          = s2_res_r.flag_v;
  assign out_flag_h          = s2_res_r.flag_h;
  assign out_flag_z          = s2_res_r.flag_z;
  assign out_flag_c          = s2_res_r.flag_c;
  assign out_flag_write_mask = s2_res_r.flag_write_mask;

  // unwritten flags read as zero
  a_mask_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_flag_n & ~out_flag_write_mask[spcalu_pkg::MB_N]) == 1'b0 &&
                   (out_flag_v & ~out_flag_write_mask[spcalu_pkg::MB_V]) == 1'b0 &&
                   (out_flag_h & ~out_flag_write_mask[spcalu_pkg::MB_H]) == 1'b0 &&
                   (out_flag_z & ~out_flag_write_mask[spcalu_pkg::MB_Z]) == 1'b0 &&
                   (out_flag_c & ~out_flag_write_mask[spcalu_pkg::MB_C]) == 1'b0))
    else $error("unwritten flag set");

  // an unused mode gives a zero result
  a_nop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flag_write_mask == spcalu_pkg::MASK_NONE) |-> out_result == 16'd0)
    else $error("no-op result not zero");

  // input only stalls with both registers full and the output held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid && out_stall))
    else $error("input stalled without back-pressure");

  // a captured item reaches the result register when it has room
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !(out_valid && out_stall)) |=> out_valid)
    else $error("item did not advance");

endmodule
